// ===== rtl/cqs_pkg.sv =====
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared types and constants of the circular queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package cqs_pkg;

   // Request kinds carried on req_tuser.
   typedef enum logic [2:0] {
      KIND_ENQUEUE = 3'd0,
      KIND_DEQUEUE = 3'd1,
      KIND_FRONT   = 3'd2,
      KIND_REAR    = 3'd3,
      KIND_SEARCH  = 3'd4
   } kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEARCH
   } state_type;

   localparam int KIND_BITS   = 3;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;
   localparam int DATA_BITS   = 32;
   localparam int SLOT_BITS   = 7;
   localparam int OCC_BITS    = 8;
   localparam int CAP_BITS    = 8;
   localparam int RSP_BITS    = 56;
   localparam int CSR_BITS    = 32;
   localparam int CSR_ADDR_BITS = 3;

   // Capacity used when the register holds zero, and the capacity after reset.
   localparam int DEFAULT_CAP = 100;
   localparam logic [CAP_BITS-1:0] RESET_CAP = 8'd128;

   // Register select: bit 2 of the byte address picks the 32-bit register.
   localparam logic CAP_REG_SEL = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/cqs_ram.sv =====
// ----------------------------------------------------------------------------
// cqs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/circular_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_search
// Ring-buffer FIFO of words with front/rear reads and a linear search.
// ----------------------------------------------------------------------------
// Enqueue, dequeue and unused request kinds are answered from the idle state,
// so they stream at one transaction per cycle while the response side is not
// stalled. Read front and read rear pass through the read state because the
// ring lives in a memory with a registered read. A search walks the ring
// through the single read port one entry per cycle and stops at the first
// match or after the last occupied entry. Requests on an empty queue are
// answered from the idle state. The ring memory is not cleared after reset;
// only occupied slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_queue_with_search #(
   parameter int DEPTH     = 128,
   parameter int WORD_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request stream.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata: value[31:0].
   input  wire logic [cqs_pkg::VALUE_BITS-1:0]       req_tdata,
   // tuser: kind[2:0].
   input  wire logic [cqs_pkg::KIND_BITS-1:0]        req_tuser,
   // Response stream.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: status[1:0], data[33:2], found[34], slot[41:35],
   // occupancy[49:42], zero[55:50].
   output logic      [cqs_pkg::RSP_BITS-1:0]         rsp_tdata,
   // Register port.
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [cqs_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [cqs_pkg::CSR_BITS-1:0]         csr_pwdata,
   output logic      [cqs_pkg::CSR_BITS-1:0]         csr_prdata,
   output logic                                      csr_pready
);

   import cqs_pkg::*;

   localparam int MAX_CAP   = (DEPTH < 255) ? DEPTH : 255;
   localparam int DEF_EFF   = (DEFAULT_CAP < MAX_CAP) ? DEFAULT_CAP : MAX_CAP;
   localparam int PTR_BITS  = $clog2(MAX_CAP);
   localparam int CNT_BITS  = $clog2(MAX_CAP + 1);
   localparam int ADDR_BITS = $clog2(DEPTH);

   state_type               state_ff, state_in;
   logic [CAP_BITS-1:0]     cap_ff, cap_in;
   logic [CNT_BITS-1:0]     eff_ff, eff_in;
   logic [PTR_BITS-1:0]     head_ff, head_in;
   logic [PTR_BITS-1:0]     tail_ff, tail_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [PTR_BITS-1:0]     iss_ptr_ff, iss_ptr_in;
   logic [CNT_BITS-1:0]     iss_left_ff, iss_left_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [PTR_BITS-1:0]     cmp_slot_ff, cmp_slot_in;
   logic                    cmp_last_ff, cmp_last_in;
   logic [WORD_BITS-1:0]    key_ff, key_in;

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff, rsp_status_in;
   logic [DATA_BITS-1:0]    rsp_data_ff, rsp_data_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [SLOT_BITS-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [OCC_BITS-1:0]     rsp_occ_ff, rsp_occ_in;
   logic                    load_rsp;

   logic                    ram_we;
   logic [ADDR_BITS-1:0]    ram_waddr;
   logic [ADDR_BITS-1:0]    ram_raddr;
   logic [WORD_BITS-1:0]    ram_rdata;
   logic [WORD_BITS-1:0]    wval;

   logic                    rsp_free;
   logic                    req_fire;
   logic                    csr_write;
   logic [PTR_BITS-1:0]     nxt_head;
   logic [PTR_BITS-1:0]     nxt_tail;
   logic [PTR_BITS-1:0]     nxt_iss;
   logic [CNT_BITS-1:0]     wr_eff;

   // Effective ring size for a capacity register value.
   function automatic logic [CNT_BITS-1:0] eff_of(input logic [CAP_BITS-1:0] cap);
      logic [CNT_BITS-1:0] r;
      if (cap == '0) begin
         r = CNT_BITS'(DEF_EFF);
      end else if (cap > CAP_BITS'(MAX_CAP)) begin
         r = CNT_BITS'(MAX_CAP);
      end else begin
         r = CNT_BITS'(cap);
      end
      return r;
   endfunction

   // Slot after s in a ring of c slots; s is always below c.
   function automatic logic [PTR_BITS-1:0] nxt(input logic [PTR_BITS-1:0] s,
                                               input logic [CNT_BITS-1:0] c);
      logic [CNT_BITS-1:0] s1;
      s1 = CNT_BITS'(s) + 1'b1;
      return (s1 == c) ? '0 : PTR_BITS'(s1);
   endfunction

   cqs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wval),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign wval      = WORD_BITS'($unsigned(req_tdata));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign nxt_head  = nxt(head_ff, eff_ff);
   assign nxt_tail  = nxt(tail_ff, eff_ff);
   assign nxt_iss   = nxt(iss_ptr_ff, eff_ff);
   assign wr_eff    = eff_of(csr_pwdata[CAP_BITS-1:0]);

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      eff_in        = eff_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      iss_ptr_in    = iss_ptr_ff;
      iss_left_in   = iss_left_ff;
      cmp_vld_in    = 1'b0;
      cmp_slot_in   = cmp_slot_ff;
      cmp_last_in   = cmp_last_ff;
      key_in        = key_ff;
      ram_we        = 1'b0;
      ram_waddr     = ADDR_BITS'(nxt_tail);
      ram_raddr     = ADDR_BITS'(head_ff);
      load_rsp      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_data_in   = '0;
      rsp_found_in  = 1'b0;
      rsp_slot_in   = '0;
      rsp_occ_in    = OCC_BITS'(count_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (kind_type'(req_tuser))
                  KIND_ENQUEUE: begin
                     load_rsp = 1'b1;
                     if (count_ff >= eff_ff) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ram_we     = 1'b1;
                        tail_in    = nxt_tail;
                        count_in   = count_ff + 1'b1;
                        rsp_occ_in = OCC_BITS'(count_in);
                     end
                  end
                  KIND_DEQUEUE: begin
                     load_rsp = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        head_in    = nxt_head;
                        count_in   = count_ff - 1'b1;
                        rsp_occ_in = OCC_BITS'(count_in);
                     end
                  end
                  KIND_FRONT, KIND_REAR: begin
                     if (count_ff == '0) begin
                        load_rsp      = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        ram_raddr = (kind_type'(req_tuser) == KIND_FRONT) ?
                                    ADDR_BITS'(head_ff) : ADDR_BITS'(tail_ff);
                        state_in  = ST_READ;
                     end
                  end
                  KIND_SEARCH: begin
                     if (count_ff == '0) begin
                        load_rsp      = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // The first entry is read right away; later ones follow one per
                        // cycle while the compare trails the registered read.
                        ram_raddr   = ADDR_BITS'(head_ff);
                        cmp_vld_in  = 1'b1;
                        cmp_slot_in = head_ff;
                        cmp_last_in = (count_ff == CNT_BITS'(1));
                        iss_ptr_in  = nxt_head;
                        iss_left_in = count_ff - 1'b1;
                        key_in      = wval;
                        state_in    = ST_SEARCH;
                     end
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            load_rsp    = 1'b1;
            rsp_data_in = DATA_BITS'(ram_rdata);
            state_in    = ST_IDLE;
         end
         ST_SEARCH: begin
            if (cmp_vld_ff && (ram_rdata == key_ff)) begin
               load_rsp     = 1'b1;
               rsp_found_in = 1'b1;
               rsp_slot_in  = SLOT_BITS'(cmp_slot_ff);
               state_in     = ST_IDLE;
            end else if (cmp_vld_ff && cmp_last_ff) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end else if (iss_left_ff != '0) begin
               ram_raddr   = ADDR_BITS'(iss_ptr_ff);
               cmp_vld_in  = 1'b1;
               cmp_slot_in = iss_ptr_ff;
               cmp_last_in = (iss_left_ff == CNT_BITS'(1));
               iss_ptr_in  = nxt_iss;
               iss_left_in = iss_left_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Writing the capacity empties the queue.
      if (csr_write && (csr_paddr[2] == CAP_REG_SEL)) begin
         cap_in   = csr_pwdata[CAP_BITS-1:0];
         eff_in   = wr_eff;
         head_in  = '0;
         tail_in  = PTR_BITS'(wr_eff - 1'b1);
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= RESET_CAP;
         eff_ff       <= eff_of(RESET_CAP);
         head_ff      <= '0;
         tail_ff      <= PTR_BITS'(eff_of(RESET_CAP) - 1'b1);
         count_ff     <= '0;
         iss_left_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cap_ff      <= cap_in;
         eff_ff      <= eff_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         iss_left_ff <= iss_left_in;
         cmp_vld_ff  <= cmp_vld_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      iss_ptr_ff  <= iss_ptr_in;
      cmp_slot_ff <= cmp_slot_in;
      cmp_last_ff <= cmp_last_in;
      key_ff      <= key_in;
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_occ_ff, rsp_slot_ff, rsp_found_ff, rsp_data_ff,
                        rsp_status_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CAP_REG_SEL) ? CSR_BITS'(cap_ff) : '0;

endmodule

`default_nettype wire

// ===== bench/circular_queue_with_search_tb.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_search_tb
// Self-checking bench for the ring-buffer queue with search. A short table of
// directed requests and capacity writes runs first, then random phases at a
// range of capacities. Every response is compared field by field against a
// table entry or an in-bench model, with random idling on both streams outside the last phase.
// ----------------------------------------------------------------------------
module circular_queue_with_search_tb;
   import cqs_pkg::*;

   localparam int RING_DEPTH    = 128;
   localparam int NUM_PHASES    = 10;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 20;
   localparam logic [CSR_ADDR_BITS-1:0] CAP_ADDR = {CAP_REG_SEL, 2'b00};
   // Request kinds the block does not define; they must pass through untouched.
   localparam logic [KIND_BITS-1:0] KIND_SPARE_5 = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_BITS-1:0] KIND_SPARE_7 = 3'd7;

   typedef struct packed {
      status_type             status;
      logic [DATA_BITS-1:0]   data;
      logic                   found;
      logic [SLOT_BITS-1:0]   slot;
      logic [OCC_BITS-1:0]    occ;
   } result_type;

   typedef struct {
      bit                     is_cfg;
      logic [KIND_BITS-1:0]   kind;
      logic [VALUE_BITS-1:0]  value;
      bit                     typed;
      result_type             want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [VALUE_BITS-1:0] req_tdata = '0;
   logic [KIND_BITS-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_BITS-1:0] csr_pwdata = '0;
   logic [CSR_BITS-1:0] csr_prdata;
   logic csr_pready;

   // Model of the queue contents and pointers.
   logic [VALUE_BITS-1:0] ring_model [RING_DEPTH];
   logic [CAP_BITS-1:0] model_cap = RESET_CAP;
   int unsigned model_head = 0;
   int unsigned model_tail = RING_DEPTH - 1;
   int unsigned model_count = 0;

   result_type expected_rsp [$];
   stim_row_type directed [$];
   int phase_cap [NUM_PHASES];
   int phase_len [NUM_PHASES];
   int errors = 0;
   bit quiet = 1'b0;
   bit long_hold_due = 1'b0;
   bit fill_mode = 1'b1;

   circular_queue_with_search u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // A register value of zero selects the default size; larger values saturate.
   function automatic int unsigned ring_size();
      if (model_cap == 0) begin
         return DEFAULT_CAP;
      end
      if (model_cap > RING_DEPTH) begin
         return RING_DEPTH;
      end
      return 32'(model_cap);
   endfunction

   function automatic result_type predict_response(input logic [KIND_BITS-1:0] kind,
                                                   input logic [VALUE_BITS-1:0] value);
      result_type r;
      int unsigned size;
      int unsigned s;
      int unsigned n;
      r = '0;
      size = ring_size();
      case (kind)
         KIND_ENQUEUE: begin
            if (model_count >= size) begin
               r.status = STATUS_FULL;
            end else begin
               model_tail = (model_tail + 1) % size;
               ring_model[model_tail] = value;
               model_count++;
            end
         end
         KIND_DEQUEUE: begin
            if (model_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               model_head = (model_head + 1) % size;
               model_count--;
            end
         end
         KIND_FRONT, KIND_REAR: begin
            if (model_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.data = ring_model[(kind == KIND_FRONT) ? model_head : model_tail];
            end
         end
         KIND_SEARCH: begin
            if (model_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               s = model_head;
               for (n = 0; n < model_count && !r.found; n++) begin
                  if (ring_model[s] == value) begin
                     r.found = 1'b1;
                     r.slot = s[SLOT_BITS-1:0];
                  end else begin
                     s = (s + 1) % size;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      r.occ = model_count[OCC_BITS-1:0];
      return r;
   endfunction

   function automatic stim_row_type op(input logic [KIND_BITS-1:0] k,
                                       input logic [VALUE_BITS-1:0] v);
      stim_row_type row;
      row.is_cfg = 1'b0;
      row.kind = k;
      row.value = v;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic stim_row_type op_exp(input logic [KIND_BITS-1:0] k,
                                           input logic [VALUE_BITS-1:0] v,
                                           input status_type st,
                                           input logic [DATA_BITS-1:0] d,
                                           input logic f,
                                           input logic [SLOT_BITS-1:0] sl,
                                           input logic [OCC_BITS-1:0] oc);
      stim_row_type row;
      row = op(k, v);
      row.typed = 1'b1;
      row.want.status = st;
      row.want.data = d;
      row.want.found = f;
      row.want.slot = sl;
      row.want.occ = oc;
      return row;
   endfunction

   function automatic stim_row_type cfg_row(input logic [CAP_BITS-1:0] c);
      stim_row_type row;
      row = op(KIND_ENQUEUE, {24'd0, c});
      row.is_cfg = 1'b1;
      return row;
   endfunction

   task automatic report_mismatch(input string field, input logic [DATA_BITS-1:0] want,
                                  input logic [DATA_BITS-1:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
   endtask

   task automatic send_request(input logic [KIND_BITS-1:0] kind,
                               input logic [VALUE_BITS-1:0] value,
                               input bit typed,
                               input result_type want);
      result_type pred;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_response(kind, value);
      expected_rsp.push_back(typed ? want : pred);
   endtask

   // The capacity is only rewritten once the queue has answered everything.
   task automatic apply_capacity(input logic [CAP_BITS-1:0] cap);
      logic [CSR_BITS-1:0] noise;
      noise = $urandom;
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CAP_ADDR;
      csr_pwdata <= {noise[CSR_BITS-1:CAP_BITS], cap};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // Read the register straight back.
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_pready !== 1'b1 || csr_prdata !== CSR_BITS'(cap)) begin
         report_mismatch("capacity readback", CSR_BITS'(cap), csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      model_cap = cap;
      model_head = 0;
      model_tail = ring_size() - 1;
      model_count = 0;
   endtask

   // Receiver: random stalls, plus one long hold that backs the block up.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tdata[1:0]);
         got.data = rsp_tdata[33:2];
         got.found = rsp_tdata[34];
         got.slot = rsp_tdata[41:35];
         got.occ = rsp_tdata[49:42];
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected transaction", '0, rsp_tdata[31:0]);
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status) begin
               report_mismatch("status", DATA_BITS'(want.status), DATA_BITS'(got.status));
            end
            if (got.data !== want.data) report_mismatch("data", want.data, got.data);
            if (got.found !== want.found) begin
               report_mismatch("found", DATA_BITS'(want.found), DATA_BITS'(got.found));
            end
            if (got.slot !== want.slot) begin
               report_mismatch("slot", DATA_BITS'(want.slot), DATA_BITS'(got.slot));
            end
            if (got.occ !== want.occ) begin
               report_mismatch("occupancy", DATA_BITS'(want.occ), DATA_BITS'(got.occ));
            end
            if (rsp_tdata[55:50] !== 6'd0) begin
               report_mismatch("padding", '0, DATA_BITS'(rsp_tdata[55:50]));
            end
         end
      end
   end

   initial begin
      logic [KIND_BITS-1:0] kind;
      logic [VALUE_BITS-1:0] value;
      int roll;
      phase_cap = '{1, 2, 5, 128, 0, 255, 7, 1, 130, 128};
      phase_len = '{60, 80, 100, 300, 100, 80, 80, 100, 80, 70};
      phase_cap[7] = int'($urandom_range(1, 255));

      // Starts from the reset state: capacity 128, empty, tail on the last slot.
      directed.push_back(op_exp(KIND_DEQUEUE, 32'h0, STATUS_EMPTY, 32'h0, 1'b0, 7'd0, 8'd0));
      directed.push_back(op_exp(KIND_FRONT, 32'h1234_5678, STATUS_EMPTY, 32'h0, 1'b0, 7'd0, 8'd0));
      directed.push_back(op_exp(KIND_REAR, 32'h0, STATUS_EMPTY, 32'h0, 1'b0, 7'd0, 8'd0));
      directed.push_back(op_exp(KIND_SEARCH, 32'h0, STATUS_EMPTY, 32'h0, 1'b0, 7'd0, 8'd0));
      directed.push_back(op_exp(KIND_SPARE_5, 32'hFFFF_FFFF, STATUS_OK, 32'h0, 1'b0, 7'd0, 8'd0));
      directed.push_back(op_exp(KIND_SPARE_7, 32'h0, STATUS_OK, 32'h0, 1'b0, 7'd0, 8'd0));
      directed.push_back(op_exp(KIND_ENQUEUE, 32'h7FFF_FFFF, STATUS_OK, 32'h0, 1'b0, 7'd0, 8'd1));
      directed.push_back(op_exp(KIND_ENQUEUE, 32'h8000_0000, STATUS_OK, 32'h0, 1'b0, 7'd0, 8'd2));
      directed.push_back(op_exp(KIND_ENQUEUE, 32'hFFFF_FFFF, STATUS_OK, 32'h0, 1'b0, 7'd0, 8'd3));
      directed.push_back(op_exp(KIND_FRONT, 32'h0, STATUS_OK, 32'h7FFF_FFFF, 1'b0, 7'd0, 8'd3));
      directed.push_back(op_exp(KIND_REAR, 32'h0, STATUS_OK, 32'hFFFF_FFFF, 1'b0, 7'd0, 8'd3));
      directed.push_back(op_exp(KIND_SEARCH, 32'h8000_0000, STATUS_OK, 32'h0, 1'b1, 7'd1, 8'd3));
      directed.push_back(op_exp(KIND_SEARCH, 32'h0, STATUS_OK, 32'h0, 1'b0, 7'd0, 8'd3));
      directed.push_back(op_exp(KIND_SPARE_6, 32'h5555_AAAA, STATUS_OK, 32'h0, 1'b0, 7'd0, 8'd3));
      directed.push_back(op(KIND_DEQUEUE, 32'h0));
      directed.push_back(op(KIND_SEARCH, 32'hFFFF_FFFF));
      directed.push_back(cfg_row(8'd2));
      directed.push_back(op(KIND_ENQUEUE, 32'd1));
      directed.push_back(op(KIND_ENQUEUE, 32'd2));
      directed.push_back(op_exp(KIND_ENQUEUE, 32'd3, STATUS_FULL, 32'h0, 1'b0, 7'd0, 8'd2));
      directed.push_back(op(KIND_SEARCH, 32'd2));
      directed.push_back(op(KIND_DEQUEUE, 32'h0));
      directed.push_back(op(KIND_ENQUEUE, 32'd4));
      directed.push_back(op(KIND_SEARCH, 32'd4));
      directed.push_back(op(KIND_REAR, 32'h0));
      // Zero selects the default size, and 255 saturates to the full ring.
      directed.push_back(cfg_row(8'd0));
      directed.push_back(op(KIND_ENQUEUE, 32'hDEAD_BEEF));
      directed.push_back(cfg_row(8'd255));
      directed.push_back(op_exp(KIND_REAR, 32'h0, STATUS_EMPTY, 32'h0, 1'b0, 7'd0, 8'd0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_cfg) begin
            apply_capacity(directed[i].value[CAP_BITS-1:0]);
         end else begin
            send_request(directed[i].kind, directed[i].value, directed[i].typed,
                         directed[i].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_capacity(CAP_BITS'(phase_cap[p]));
         quiet = (p == NUM_PHASES - 1);
         fill_mode = 1'b1;
         for (int n = 0; n < phase_len[p]; n++) begin
            if (p == 3 && n == 150) begin
               long_hold_due = 1'b1;
            end
            // Swing between filling and draining so both full and empty are hit.
            if (model_count >= ring_size() && $urandom_range(0, 7) == 0) begin
               fill_mode = 1'b0;
            end else if (model_count == 0 && $urandom_range(0, 3) == 0) begin
               fill_mode = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               kind = fill_mode ? KIND_ENQUEUE : KIND_DEQUEUE;
            end else if (roll < 65) begin
               kind = fill_mode ? KIND_DEQUEUE : KIND_ENQUEUE;
            end else if (roll < 73) begin
               kind = KIND_FRONT;
            end else if (roll < 81) begin
               kind = KIND_REAR;
            end else if (roll < 97) begin
               kind = KIND_SEARCH;
            end else begin
               kind = KIND_BITS'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
            end
            // A small pool of values makes duplicates, so the first match matters.
            roll = $urandom_range(0, 9);
            if (roll < 2) begin
               value = $urandom_range(0, 7);
            end else if (roll < 4) begin
               value = -$urandom_range(1, 8);
            end else if (roll == 4) begin
               case ($urandom_range(0, 3))
                  0: value = 32'h8000_0000;
                  1: value = 32'h7FFF_FFFF;
                  2: value = 32'hFFFF_FFFF;
                  default: value = 32'h0;
               endcase
            end else begin
               value = $urandom;
            end
            if (kind == KIND_SEARCH && model_count != 0 && $urandom_range(0, 1) == 1) begin
               value = ring_model[(model_head + $urandom_range(0, model_count - 1))
                                  % ring_size()];
            end
            send_request(kind, value, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
